>>> rtl/core/bfnsb_pkg.sv
// shared types, constants and a helper function for the next-set-bit bitmap block
package bfnsb_pkg;

    // bitmap geometry
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = 8;
    localparam int WORD_SHIFT = $clog2(WORD_BITS);
    localparam int SEL_W      = $clog2(MAP_WORDS);

    // field widths
    localparam int OP_W   = 1;
    localparam int IDX_W  = 3;
    localparam int POS_W  = 9;
    localparam int WCNT_W = POS_W - WORD_SHIFT;

    // opcodes
    localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
    localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

    // halving masks for the find-first-set
    localparam logic [WORD_BITS-1:0] MASK_16 = 32'h0000_ffff;
    localparam logic [WORD_BITS-1:0] MASK_8  = 32'h0000_00ff;
    localparam logic [WORD_BITS-1:0] MASK_4  = 32'h0000_000f;
    localparam logic [WORD_BITS-1:0] MASK_2  = 32'h0000_0003;
    localparam logic [WORD_BITS-1:0] MASK_1  = 32'h0000_0001;

    // controller to datapath commands
    typedef struct packed {
        logic write_en;
        logic load_query;
        logic advance;
        logic load_result;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
    } dp_status_t;

    // index of the lowest set bit of a nonzero word
    function automatic logic [WORD_SHIFT-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0]  v;
        logic [WORD_SHIFT-1:0] n;
        v = w;
        n = '0;
        if ((v & MASK_16) == '0)
        begin
            n = n + WORD_SHIFT'(16);
            v = v >> 16;
        end
        if ((v & MASK_8) == '0)
        begin
            n = n + WORD_SHIFT'(8);
            v = v >> 8;
        end
        if ((v & MASK_4) == '0)
        begin
            n = n + WORD_SHIFT'(4);
            v = v >> 4;
        end
        if ((v & MASK_2) == '0)
        begin
            n = n + WORD_SHIFT'(2);
            v = v >> 2;
        end
        if ((v & MASK_1) == '0)
        begin
            n = n + WORD_SHIFT'(1);
        end
        return n;
    endfunction

endpackage

>>> rtl/core/bfnsb_cmd_if.sv
// input channel: bitmap word writes and search queries
interface bfnsb_cmd_if;
    import bfnsb_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_BITS-1:0] word_data;
    logic [POS_W-1:0]  search_limit;
    logic [POS_W-1:0]  start_bit;

    modport source (
        output valid, opcode, word_index, word_data, search_limit, start_bit,
        input  ready
    );

    modport sink (
        input  valid, opcode, word_index, word_data, search_limit, start_bit,
        output ready
    );
endinterface

>>> rtl/core/bfnsb_res_if.sv
// output channel: search results
interface bfnsb_res_if;
    import bfnsb_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] next_index;
    logic             none_found;

    modport source (
        output valid, next_index, none_found,
        input  ready
    );

    modport sink (
        input  valid, next_index, none_found,
        output ready
    );
endinterface

>>> rtl/core/bitmap_find_next_set_bit.sv
// top level of the next-set-bit search over a word-organised bitmap
//
// cmd channel: one transaction per write or search. opcode write stores
// word_data into word word_index and produces no result; opcode search
// returns the lowest set bit in [start_bit, search_limit), or search_limit
// with none_found high when there is none.
// res channel: one transaction per search, in the order searches arrive.
// a write is absorbed in its accepting cycle, so cmd stays ready for the
// next transaction. a search occupies the word scanner: one stored word is
// masked and examined per cycle, from the word holding start_bit upward,
// so the result is registered once the scan ends, and cmd is ready again
// in the cycle in which the result first appears.
// the result sits in an output register; a new transaction is accepted
// while it waits. if the receiver stalls and a second search finishes,
// the scanner holds its answer and cmd stays low until the register frees.
// reset clears the bitmap to all zeros and empties the output register.
module bitmap_find_next_set_bit (
    input  logic        clk,
    input  logic        rst_n,
    bfnsb_cmd_if.sink   cmd,
    bfnsb_res_if.source res
);
    import bfnsb_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    // sequencing
    bfnsb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_opcode (cmd.opcode),
        .cmd_ready  (cmd.ready),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .status     (status),
        .ctrl       (ctrl)
    );

    // storage and search logic
    bfnsb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .word_index   (cmd.word_index),
        .word_data    (cmd.word_data),
        .search_limit (cmd.search_limit),
        .start_bit    (cmd.start_bit),
        .next_index   (res.next_index),
        .none_found   (res.none_found)
    );
endmodule

>>> rtl/core/bfnsb_ctrl.sv
// controller: accepts transactions, sequences the word scan, owns the result valid
module bfnsb_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  logic [bfnsb_pkg::OP_W-1:0]   cmd_opcode,
    output logic                         cmd_ready,
    output logic                         res_valid,
    input  logic                         res_ready,
    input  bfnsb_pkg::dp_status_t        status,
    output bfnsb_pkg::ctrl_cmd_t         ctrl
);
    import bfnsb_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;
    logic res_valid_reg;
    logic res_valid_next;
    logic accept;
    logic slot_free;

    assign accept    = cmd_valid && cmd_ready;
    assign slot_free = !res_valid_reg || res_ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_opcode == OP_SEARCH)
                    begin
                        ctrl.load_query = 1'b1;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        ctrl.write_en = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    // hold the finished result until the output register frees up
                    if (slot_free)
                    begin
                        ctrl.load_result = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
                else
                begin
                    ctrl.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        if (ctrl.load_result)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end
endmodule

>>> rtl/core/bfnsb_dp.sv
// datapath: bitmap words, query registers, per-word masking and find-first-set
module bfnsb_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bfnsb_pkg::ctrl_cmd_t              ctrl,
    output bfnsb_pkg::dp_status_t             status,
    input  logic [bfnsb_pkg::IDX_W-1:0]       word_index,
    input  logic [bfnsb_pkg::WORD_BITS-1:0]   word_data,
    input  logic [bfnsb_pkg::POS_W-1:0]       search_limit,
    input  logic [bfnsb_pkg::POS_W-1:0]       start_bit,
    output logic [bfnsb_pkg::POS_W-1:0]       next_index,
    output logic                              none_found
);
    import bfnsb_pkg::*;

    logic [WORD_BITS-1:0] store_reg [MAP_WORDS];
    logic [POS_W-1:0]     limit_reg;
    logic [POS_W-1:0]     start_reg;
    logic [WCNT_W-1:0]    word_reg;
    logic [POS_W-1:0]     index_reg;
    logic                 none_reg;

    logic                 in_map;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] masked;
    logic [POS_W-1:0]     base;
    logic [POS_W-1:0]     pos;
    logic                 hit;
    logic [POS_W-1:0]     found_index;
    logic                 wr_in_map;

    // current word, zero past the end of the map
    assign in_map   = (word_reg < WCNT_W'(MAP_WORDS));
    assign cur_word = in_map ? store_reg[word_reg[SEL_W-1:0]] : '0;
    assign base     = POS_W'(word_reg) << WORD_SHIFT;

    // keep only bits inside [start, limit)
    always_comb
    begin
        masked = '0;
        pos    = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            pos       = base + POS_W'(j);
            masked[j] = cur_word[j] && (pos >= start_reg) && (pos < limit_reg);
        end
    end

    assign hit         = (masked != '0);
    assign found_index = base + POS_W'(lowest_set(masked));

    assign status.scan_done = (start_reg >= limit_reg) || !in_map
                              || (base >= limit_reg) || hit;

    assign wr_in_map = (IDX_W'(word_index) < IDX_W'(MAP_WORDS - 1)) ||
                       (word_index == IDX_W'(MAP_WORDS - 1));

    // bitmap words, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_WORDS; i++)
                store_reg[i] <= '0;
        end
        else if (ctrl.write_en && wr_in_map)
        begin
            store_reg[word_index[SEL_W-1:0]] <= word_data;
        end
    end

    // query registers and word counter
    always_ff @(posedge clk)
    begin
        if (ctrl.load_query)
        begin
            limit_reg <= search_limit;
            start_reg <= start_bit;
            word_reg  <= start_bit[POS_W-1:WORD_SHIFT];
        end
        else if (ctrl.advance)
        begin
            word_reg <= word_reg + WCNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.load_result)
        begin
            index_reg <= hit ? found_index : limit_reg;
            none_reg  <= !hit;
        end
    end

    assign next_index = index_reg;
    assign none_found = none_reg;
endmodule

>>> rtl/core/bfnsb_checker.sv
// port-level checks for the next-set-bit block, bound to the top level
module bfnsb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic [bfnsb_pkg::OP_W-1:0]    cmd_opcode,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [bfnsb_pkg::POS_W-1:0]   res_next_index,
    input logic                          res_none_found
);
    import bfnsb_pkg::*;

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_next_index) && $stable(res_none_found))
        else $error("result payload changed while stalled");

    // a search keeps the scanner busy for at least the next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_opcode == OP_SEARCH) |=> !cmd_ready)
        else $error("new transaction taken while a search is scanning");

    // a write completes in its accepting cycle
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_opcode == OP_WRITE) |=> cmd_ready)
        else $error("write stalled the command channel");
endmodule

bind bitmap_find_next_set_bit bfnsb_checker u_bfnsb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_opcode     (cmd.opcode),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_next_index (res.next_index),
    .res_none_found (res.none_found)
);
